@@ hdl/tpms_frame_parser_assert.svh @@
// assertion macros shared by the frame parser modules
`ifndef TPMS_FRAME_PARSER_ASSERT_SVH
`define TPMS_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define TFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpms_frame_parser: check failed");
// next-cycle implication, disabled during reset
`define TFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpms_frame_parser: check failed");
`else
`define TFP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TFP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/tpms_fp_pkg.sv @@
// types, constants and status codes of the tire sensor frame parser
package tpms_fp_pkg;

    // frame length window in bits
    localparam int FRAME_BITS    = 80;
    localparam int LENGTH_MARGIN = 16;
    localparam logic [7:0] LEN_MIN   = 8'(FRAME_BITS);
    localparam logic [7:0] LEN_LIMIT = 8'(FRAME_BITS + LENGTH_MARGIN);

    // byte store and counter
    localparam int STORE_DEPTH = 10;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // queue between classifier and decoder
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_BAD_PRE  = 3'd2;
    localparam logic [2:0] ST_BAD_TRL  = 3'd3;
    localparam logic [2:0] ST_BAD_CSUM = 3'd4;

    // fixed-point scaling constants, preamble byte and checksum carry flag
    localparam logic [8:0]  PRESS_MUL  = 9'd372;
    localparam logic [16:0] PRESS_OFS  = 17'd71;
    localparam logic [12:0] TEMP_MUL   = 13'd18;
    localparam logic [12:0] TEMP_OFS   = 13'd580;
    localparam logic [7:0]  PREAMBLE   = 8'hff;
    localparam logic [7:0]  CSUM_CARRY = 8'h80;

    // classified frame handed from front to back
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] csum;
        logic [7:0] id_hi;
        logic [7:0] id_mid;
        logic [7:0] id_lo;
        logic [7:0] press;
        logic [7:0] temp;
        logic [7:0] flags;
    } t_frame_rec;

endpackage

@@ hdl/tpms_fp_front.sv @@
// byte intake: inversion, byte store, length, preamble and trailer checks
module tpms_fp_front import tpms_fp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_raw_byte,
    input  logic       i_last_byte,
    input  logic [3:0] i_tail_bits,
    output logic       o_stall,
    input  logic       i_full,
    output logic       o_push,
    output t_frame_rec o_rec
);
    `include "tpms_frame_parser_assert.svh"

    logic [3:0] r_count;
    logic [3:0] n_count;
    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] n_view  [STORE_DEPTH];
    logic       w_accept;
    logic [7:0] w_inv;
    logic [3:0] w_count_inc;
    logic [7:0] w_bits;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_inv    = ~i_raw_byte;

    // saturating byte count including this byte
    assign w_count_inc = (r_count < COUNT_MAX) ? r_count + 4'd1 : r_count;

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = i_last_byte ? 4'd0 : w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // byte store, written at the current count
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (w_accept && r_count == 4'(k)) begin
                r_store[k] <= w_inv;
            end
        end
    end

    // store as seen with this byte already written
    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            n_view[k] = (r_count == 4'(k)) ? w_inv : r_store[k];
        end
    end

    // frame length in bits
    assign w_bits = {1'b0, w_count_inc - 4'd1, 3'b000} + {4'b0000, i_tail_bits};

    // classify in check order, checksum left to the back end
    always_comb begin
        o_rec.status = ST_OK;
        if (w_bits < LEN_MIN || w_bits >= LEN_LIMIT) begin
            o_rec.status = ST_BAD_LEN;
        end else if (n_view[0] != PREAMBLE || n_view[1] != PREAMBLE) begin
            o_rec.status = ST_BAD_PRE;
        end else if (n_view[9] != 8'h00) begin
            o_rec.status = ST_BAD_TRL;
        end
        o_rec.csum   = n_view[2];
        o_rec.id_hi  = n_view[3];
        o_rec.id_mid = n_view[4];
        o_rec.id_lo  = n_view[5];
        o_rec.press  = n_view[6];
        o_rec.temp   = n_view[7];
        o_rec.flags  = n_view[8];
    end

    assign o_push = w_accept && i_last_byte;

    // count restarts after the last byte of a packet
    `TFP_ASSERT_NXT(a_count_restart, i_clk, i_rst_n, o_push, r_count == 4'd0)
    // nothing is pushed while the queue is full
    `TFP_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_full, !o_push)

endmodule

@@ hdl/tpms_fp_queue.sv @@
// short queue of classified frames between front and back
module tpms_fp_queue import tpms_fp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_nonempty,
    output t_frame_rec o_rec
);
    `include "tpms_frame_parser_assert.svh"

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    assign o_full     = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_rec      = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pop only from a filled queue
    `TFP_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_cnt != '0)
    // fill count stays within depth
    `TFP_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_W'(QUEUE_DEPTH))

endmodule

@@ hdl/tpms_fp_back.sv @@
// checksum check, unit scaling and result register
module tpms_fp_back import tpms_fp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_frame_rec  i_rec,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [23:0] o_sensor_id,
    output logic [16:0] o_pressure_fx,
    output logic [7:0]  o_temp_raw,
    output logic signed [12:0] o_temp_tenths_f,
    output logic [7:0]  o_flag_byte,
    output logic        o_low_battery,
    output logic        o_inflating,
    output logic        o_rapid_leak
);
    logic        r_valid;
    logic        w_load;
    logic [10:0] w_sum;
    logic [7:0]  w_chk;
    logic [2:0]  w_status;
    logic [16:0] w_press_prod;
    logic [16:0] w_press;
    logic [12:0] w_temp;
    logic        w_good;

    assign w_load = i_nonempty && (!r_valid || !i_stall);
    assign o_pop  = w_load;

    // checksum over bytes 3 to 8 with carry flag
    assign w_sum = {3'b000, i_rec.id_hi} + {3'b000, i_rec.id_mid} + {3'b000, i_rec.id_lo}
                 + {3'b000, i_rec.press} + {3'b000, i_rec.temp} + {3'b000, i_rec.flags};
    assign w_chk = w_sum[7:0] | ((w_sum > 11'd255) ? CSUM_CARRY : 8'h00);

    always_comb begin
        w_status = i_rec.status;
        if (i_rec.status == ST_OK && w_chk != i_rec.csum) begin
            w_status = ST_BAD_CSUM;
        end
    end
    assign w_good = (w_status == ST_OK);

    // pressure and temperature scaling
    assign w_press_prod = {9'd0, i_rec.press} * {8'd0, PRESS_MUL};
    assign w_press      = (w_press_prod > PRESS_OFS) ? w_press_prod - PRESS_OFS : 17'd0;
    assign w_temp       = {5'd0, i_rec.temp} * TEMP_MUL - TEMP_OFS;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_load || (r_valid && i_stall);
        end
    end

    // result fields other than status, zero on a failed frame
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_status        <= w_status;
            o_sensor_id     <= w_good ? {i_rec.id_hi, i_rec.id_mid, i_rec.id_lo} : 24'd0;
            o_pressure_fx   <= w_good ? w_press : 17'd0;
            o_temp_raw      <= w_good ? i_rec.temp : 8'd0;
            o_temp_tenths_f <= w_good ? $signed(w_temp) : 13'sd0;
            o_flag_byte     <= w_good ? i_rec.flags : 8'd0;
            o_low_battery   <= w_good && i_rec.flags[7];
            o_inflating     <= w_good && i_rec.flags[5];
            o_rapid_leak    <= w_good && !i_rec.flags[5] && i_rec.flags[4];
        end
    end

    assign o_valid = r_valid;

endmodule

@@ hdl/tpms_frame_parser.sv @@
// top level of the tire pressure sensor frame parser
// throughput: one byte per cycle while o_stall is low, frames may follow each other without gaps
// a frame record is queued when its last byte is taken, then loaded into the result register
// the result register and a two-entry frame queue let the input run while a result is stalled
// reset: synchronous active-low, clears byte count, queue pointers, queue fill count and output valid
// the byte store and result fields hold no reset value
module tpms_frame_parser import tpms_fp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_last_byte,
    input  logic [3:0]  i_tail_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [23:0] o_sensor_id,
    output logic [16:0] o_pressure_fx,
    output logic [7:0]  o_temp_raw,
    output logic signed [12:0] o_temp_tenths_f,
    output logic [7:0]  o_flag_byte,
    output logic        o_low_battery,
    output logic        o_inflating,
    output logic        o_rapid_leak
);
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_nonempty;
    t_frame_rec w_front_rec;
    t_frame_rec w_queue_rec;

    // byte intake and frame classification
    tpms_fp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_raw_byte  (i_raw_byte),
        .i_last_byte (i_last_byte),
        .i_tail_bits (i_tail_bits),
        .o_stall     (o_stall),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_rec       (w_front_rec)
    );

    // frame queue
    tpms_fp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_rec      (w_front_rec),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_rec      (w_queue_rec)
    );

    // checksum and decode
    tpms_fp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (w_nonempty),
        .i_rec           (w_queue_rec),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_sensor_id     (o_sensor_id),
        .o_pressure_fx   (o_pressure_fx),
        .o_temp_raw      (o_temp_raw),
        .o_temp_tenths_f (o_temp_tenths_f),
        .o_flag_byte     (o_flag_byte),
        .o_low_battery   (o_low_battery),
        .o_inflating     (o_inflating),
        .o_rapid_leak    (o_rapid_leak)
    );

endmodule

@@ sim/tpms_frame_parser_tb.sv @@
// testbench of the tire pressure sensor frame parser with byte stimulus and result checking
module tpms_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpms_fp_pkg::*;

    localparam int BYTE_TARGET  = 2000;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // one decoded frame result as seen on the output ports
    typedef struct packed {
        logic [2:0]         status;
        logic [23:0]        sensor_id;
        logic [16:0]        pressure_fx;
        logic [7:0]         temp_raw;
        logic signed [12:0] temp_tenths_f;
        logic [7:0]         flag_byte;
        logic               low_battery;
        logic               inflating;
        logic               rapid_leak;
    } frame_result_t;

    // frame decoder prediction and result comparison
    class frame_scoreboard;
        logic [3:0]    byte_count;
        logic [7:0]    frame_bytes [STORE_DEPTH];
        frame_result_t pending_results [$];
        int            errors;
        int            bytes_noted;
        int            status_seen [5];

        function new();
            byte_count = '0;
            foreach (frame_bytes[k]) frame_bytes[k] = '0;
            errors = 0;
            bytes_noted = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // decode one accepted byte and queue the frame result it causes
        function void note_byte(logic [7:0] raw, logic last, logic [3:0] tail);
            logic [7:0]    inv;
            logic [7:0]    chk;
            int            bits;
            int            sum;
            int            p;
            int            t;
            frame_result_t r;
            inv = ~raw;
            bytes_noted++;
            if (byte_count < STORE_DEPTH) frame_bytes[byte_count] = inv;
            if (byte_count < COUNT_MAX) byte_count++;
            if (!last) return;
            bits = (int'(byte_count) - 1) * 8 + int'(tail);
            byte_count = '0;
            r = '0;
            if (bits < FRAME_BITS || bits >= FRAME_BITS + LENGTH_MARGIN) begin
                r.status = ST_BAD_LEN;
            end else if (frame_bytes[0] != PREAMBLE || frame_bytes[1] != PREAMBLE) begin
                r.status = ST_BAD_PRE;
            end else if (frame_bytes[9] != 8'h00) begin
                r.status = ST_BAD_TRL;
            end else begin
                sum = 0;
                for (int k = 3; k <= 8; k++) sum += int'(frame_bytes[k]);
                chk = sum[7:0] | ((sum > 255) ? CSUM_CARRY : 8'h00);
                if (chk != frame_bytes[2]) begin
                    r.status = ST_BAD_CSUM;
                end else begin
                    r.status      = ST_OK;
                    r.sensor_id   = {frame_bytes[3], frame_bytes[4], frame_bytes[5]};
                    p = int'(frame_bytes[6]) * 372;
                    r.pressure_fx = (p > 71) ? 17'(p - 71) : 17'd0;
                    r.temp_raw    = frame_bytes[7];
                    t = int'(frame_bytes[7]) * 18 - 580;
                    r.temp_tenths_f = t[12:0];
                    r.flag_byte   = frame_bytes[8];
                    r.low_battery = frame_bytes[8][7];
                    r.inflating   = frame_bytes[8][5];
                    r.rapid_leak  = frame_bytes[8][5] ? 1'b0 : frame_bytes[8][4];
                end
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [23:0] got, logic [23:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // compare one result transfer against the oldest prediction
        task check_result(frame_result_t got);
            frame_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no frame pending");
                return;
            end
            want = pending_results.pop_front();
            if (want.status <= ST_BAD_CSUM) status_seen[want.status]++;
            compare_field("status", got.status, want.status);
            compare_field("sensor_id", got.sensor_id, want.sensor_id);
            compare_field("pressure_fx", got.pressure_fx, want.pressure_fx);
            compare_field("temp_raw", got.temp_raw, want.temp_raw);
            compare_field("temp_tenths_f", got.temp_tenths_f, want.temp_tenths_f);
            compare_field("flag_byte", got.flag_byte, want.flag_byte);
            compare_field("low_battery", got.low_battery, want.low_battery);
            compare_field("inflating", got.inflating, want.inflating);
            compare_field("rapid_leak", got.rapid_leak, want.rapid_leak);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_raw_byte = '0;
    logic               i_last_byte = 1'b0;
    logic [3:0]         i_tail_bits = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [2:0]         o_status;
    logic [23:0]        o_sensor_id;
    logic [16:0]        o_pressure_fx;
    logic [7:0]         o_temp_raw;
    logic signed [12:0] o_temp_tenths_f;
    logic [7:0]         o_flag_byte;
    logic               o_low_battery;
    logic               o_inflating;
    logic               o_rapid_leak;

    frame_scoreboard board = new();
    bit  idle_on = 1'b0;
    bit  stall_on = 1'b0;
    int  stall_left = 0;
    int  quiet_cycles = 0;

    tpms_frame_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_raw_byte      (i_raw_byte),
        .i_last_byte     (i_last_byte),
        .i_tail_bits     (i_tail_bits),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_sensor_id     (o_sensor_id),
        .o_pressure_fx   (o_pressure_fx),
        .o_temp_raw      (o_temp_raw),
        .o_temp_tenths_f (o_temp_tenths_f),
        .o_flag_byte     (o_flag_byte),
        .o_low_battery   (o_low_battery),
        .o_inflating     (o_inflating),
        .o_rapid_leak    (o_rapid_leak)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check each transfer, then stall in random bursts
    always @(posedge i_clk) begin : rx_side
        frame_result_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.status        = o_status;
            got.sensor_id     = o_sensor_id;
            got.pressure_fx   = o_pressure_fx;
            got.temp_raw      = o_temp_raw;
            got.temp_tenths_f = o_temp_tenths_f;
            got.flag_byte     = o_flag_byte;
            got.low_battery   = o_low_battery;
            got.inflating     = o_inflating;
            got.rapid_leak    = o_rapid_leak;
            board.check_result(got);
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (stall_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // present one byte, with an optional idle burst ahead of it
    task automatic send_byte(logic [7:0] raw, logic last, logic [3:0] tail);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_raw_byte  <= raw;
        i_last_byte <= last;
        i_tail_bits <= tail;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_byte(raw, last, tail);
    endtask

    // send decoded frame bytes inverted on the line, tail count on the last one
    task automatic send_packet(logic [7:0] fb [$], logic [3:0] tail);
        logic last;
        for (int k = 0; k < fb.size(); k++) begin
            last = (k == fb.size() - 1);
            send_byte(~fb[k], last, last ? tail : 4'($urandom_range(0, 15)));
        end
    endtask

    // mostly well-formed frames with random content, some broken, some noise
    task automatic send_random_packet();
        logic [7:0] fb [$];
        logic [3:0] tail;
        int         sum;
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 20)) fb.push_back(8'($urandom));
            tail = 4'($urandom_range(0, 15));
        end else begin
            fb = {PREAMBLE, PREAMBLE, 8'h00};
            repeat (6) fb.push_back(8'($urandom));
            fb.push_back(8'h00);
            sum = 0;
            for (int k = 3; k <= 8; k++) sum += int'(fb[k]);
            fb[2] = sum[7:0] | ((sum > 255) ? CSUM_CARRY : 8'h00);
            // lengths inside the window
            case ($urandom_range(0, 2))
                0: tail = 4'($urandom_range(8, 15));
                1: begin
                    fb.push_back(8'($urandom));
                    tail = 4'($urandom_range(0, 15));
                end
                default: begin
                    repeat (2) fb.push_back(8'($urandom));
                    tail = 4'($urandom_range(0, 7));
                end
            endcase
            // break one check now and then
            case ($urandom_range(0, 9))
                0: fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
                1: fb[9] = 8'($urandom_range(1, 255));
                2: fb[2] ^= 8'($urandom_range(1, 255));
                3: begin
                    while (fb.size() > 10) void'(fb.pop_back());
                    if ($urandom_range(0, 1) == 0) begin
                        tail = 4'($urandom_range(0, 7));
                    end else begin
                        repeat ($urandom_range(3, 8)) fb.push_back(8'($urandom));
                        tail = 4'($urandom_range(0, 15));
                    end
                end
                default: ;
            endcase
        end
        send_packet(fb, tail);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone short byte, frame with zero id and readings, saturated frame with carry
        send_byte(8'h00, 1'b1, 4'd0);
        send_packet({PREAMBLE, PREAMBLE, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h30, 8'h00}, 4'd8);
        send_packet({PREAMBLE, PREAMBLE, 8'h8b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                     8'h10, 8'h00, 8'h00}, 4'd15);

        // random frames, no idling or stalling in the closing stretch
        while (board.bytes_noted < BYTE_TARGET) begin
            if (board.bytes_noted < BYTE_TARGET * 8 / 10) begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end else begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            send_random_packet();
        end
        i_valid <= 1'b0;

        // drain outstanding results
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes; frames ok %0d, bad length %0d, bad preamble %0d,",
                 board.bytes_noted, board.status_seen[ST_OK], board.status_seen[ST_BAD_LEN],
                 board.status_seen[ST_BAD_PRE]);
        $display("bad trailer %0d, checksum error %0d, mismatches %0d",
                 board.status_seen[ST_BAD_TRL], board.status_seen[ST_BAD_CSUM], board.errors);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
